// ===== src/wsu_pkg.sv =====
// Package for the WebSocket frame unmasker.
// Holds the header constants, the status codes and the beat and result types.
// No dependencies.
package wsu_pkg;

  localparam logic [7:0] HdrFin    = 8'h80;
  localparam logic [3:0] OpText    = 4'h1;
  localparam logic [3:0] OpBinary  = 4'h2;
  localparam logic [3:0] OpClose   = 4'h8;
  localparam logic [2:0] PosKey0   = 3'd2;
  localparam logic [2:0] PosPayload = 3'd6;

  typedef enum logic [1:0] {
    ST_TEXT    = 2'd0,
    ST_BINARY  = 2'd1,
    ST_CLOSE   = 2'd2,
    ST_INVALID = 2'd3
  } wsu_status_e;

  // One raw byte of the received buffer.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } wsu_beat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    wsu_status_e frame_status;
  } wsu_result_t;

endpackage

// ===== src/wsu_in_reg.sv =====
// Input register stage of the WebSocket frame unmasker.
// Captures one byte beat and holds it until the next stage takes it.
// Depends on wsu_pkg.
module wsu_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wsu_pkg::wsu_beat_t beat_i,
  input  logic              take_i,
  output logic              valid_o,
  output wsu_pkg::wsu_beat_t beat_o
);
  import wsu_pkg::*;

  logic      valid_q, valid_d;
  wsu_beat_t beat_q;
  logic      load;

  // The stage can load when it is empty or its beat leaves this cycle.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register carries no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;
endmodule

// ===== src/wsu_unmask.sv =====
// Frame tracking and unmasking logic of the WebSocket frame unmasker.
// Keeps position, header, mask key and mask pointer; builds one result per beat.
// Depends on wsu_pkg.
module wsu_unmask (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  wsu_pkg::wsu_beat_t  beat_i,
  output wsu_pkg::wsu_result_t result_o
);
  import wsu_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic [7:0] hdr_q, hdr_d;
  logic [1:0] mptr_q, mptr_d;
  logic [7:0] key_q [4];
  logic       key_we;
  logic [1:0] key_idx;
  logic [2:0] key_off;
  logic [7:0] hdr;
  logic [3:0] op;
  logic       fin;
  logic       is_data;
  logic       in_payload;

  // Header in effect for this beat: the byte itself at position zero.
  assign hdr        = (pos_q == 3'd0) ? beat_i.rx_byte : hdr_q;
  assign op         = hdr[3:0];
  assign fin        = (hdr & HdrFin) != 8'h00;
  assign is_data    = (op == OpText) || (op == OpBinary);
  assign in_payload = pos_q >= PosPayload;
  assign key_off    = pos_q - PosKey0;
  assign key_idx    = key_off[1:0];
  assign key_we     = advance_i && (pos_q >= PosKey0) && !in_payload;

  // Result for the current beat.
  always_comb begin
    result_o.payload_byte  = 8'h00;
    result_o.payload_valid = 1'b0;
    result_o.frame_done    = beat_i.buffer_end;
    result_o.frame_status  = ST_TEXT;
    if (in_payload && fin && is_data) begin
      result_o.payload_byte  = beat_i.rx_byte ^ key_q[mptr_q];
      result_o.payload_valid = 1'b1;
    end
    if (beat_i.buffer_end) begin
      if ((pos_q == 3'd0) || !fin) begin
        result_o.frame_status = ST_INVALID;
      end else if (is_data) begin
        if (!in_payload) begin
          result_o.frame_status = ST_INVALID;
        end else if (op == OpText) begin
          result_o.frame_status = ST_TEXT;
        end else begin
          result_o.frame_status = ST_BINARY;
        end
      end else if (op == OpClose) begin
        result_o.frame_status = ST_CLOSE;
      end else begin
        result_o.frame_status = ST_INVALID;
      end
    end
  end

  // Next state: position saturates in the payload, restarts after the last byte.
  always_comb begin
    pos_d  = pos_q;
    hdr_d  = hdr_q;
    mptr_d = mptr_q;
    if (advance_i) begin
      if (pos_q == 3'd0) begin
        hdr_d  = beat_i.rx_byte;
        mptr_d = 2'd0;
      end else if (in_payload) begin
        mptr_d = mptr_q + 2'd1;
      end
      if (beat_i.buffer_end) begin
        pos_d  = 3'd0;
        mptr_d = 2'd0;
      end else if (!in_payload) begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 3'd0;
      hdr_q  <= 8'h00;
      mptr_q <= 2'd0;
    end else begin
      pos_q  <= pos_d;
      hdr_q  <= hdr_d;
      mptr_q <= mptr_d;
    end
  end

  // Mask key bytes are written at positions two to five before any read.
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[key_idx] <= beat_i.rx_byte;
    end
  end
endmodule

// ===== src/websocket_frame_unmask.sv =====
// Top level of the WebSocket frame unmasker.
// Instantiates wsu_in_reg and wsu_unmask and holds the result register.
// Depends on wsu_pkg.
//
//  channel | handshake               | payload
//  --------+-------------------------+---------------------------------------------
//  in      | in_valid_i / in_stall_o | rx_byte_i, buffer_end_i
//  out     | out_valid_o/out_stall_i | payload_byte_o, payload_valid_o,
//          |                         | frame_done_o, frame_status_o
//
// One byte beat per cycle is sustained while out_stall_i stays low. A result passes
// through the input register, then the result register, before it is presented.
// Reset clears position, header, mask pointer and both valid flags; the mask
// key is not reset and is always written before it is used.
// A stalled result register holds; the input register still takes one more beat if it is empty.
module websocket_frame_unmask (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       buffer_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] payload_byte_o,
  output logic       payload_valid_o,
  output logic       frame_done_o,
  output logic [1:0] frame_status_o
);
  import wsu_pkg::*;

  wsu_beat_t   in_beat, s1_beat;
  wsu_result_t res, res_q;
  logic        s1_valid;
  logic        out_ready;
  logic        advance;
  logic        out_valid_q, out_valid_d;

  assign in_beat.rx_byte    = rx_byte_i;
  assign in_beat.buffer_end = buffer_end_i;

  // The result register can load when empty or when its beat is taken.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign advance   = s1_valid && out_ready;

  wsu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .beat_i     (in_beat),
    .take_i     (advance),
    .valid_o    (s1_valid),
    .beat_o     (s1_beat)
  );

  wsu_unmask u_unmask (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .beat_i    (s1_beat),
    .result_o  (res)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = res_q.payload_byte;
  assign payload_valid_o = res_q.payload_valid;
  assign frame_done_o    = res_q.frame_done;
  assign frame_status_o  = res_q.frame_status;

  // A payload byte on the last beat belongs to a good text or binary frame.
  a_payload_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o && frame_done_o |->
      (frame_status_o == ST_TEXT) || (frame_status_o == ST_BINARY))
    else $error("payload byte on a frame that is not good text or binary");

  // The status is zero except on the last beat.
  a_status_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_done_o |-> frame_status_o == ST_TEXT)
    else $error("status set on a beat that is not the last");

  // Bytes that are not payload read as zero.
  a_payload_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_byte_o == 8'h00)
    else $error("non-payload result carries a nonzero byte");

  // The input stalls only while the result register is full and stalled.
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a stalled result");
endmodule

// ===== test/websocket_frame_unmask_tb.sv =====
// Testbench for websocket_frame_unmask: sends whole receive buffers beat by beat,
// predicts every result beat in a scoreboard class and checks the outputs field by field.
// Depends on wsu_pkg and the websocket_frame_unmask RTL.
module websocket_frame_unmask_tb;
  import wsu_pkg::*;

  // Tracks the frame parser state and holds the unmasked results still to come.
  class unmask_scoreboard;
    logic [2:0]  position;
    logic [7:0]  header;
    logic [31:0] key;
    logic [1:0]  key_ptr;
    wsu_result_t expected_q[$];
    int          errors;

    function new();
      position = '0;
      header   = '0;
      key      = '0;
      key_ptr  = '0;
      errors   = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Status given on the last byte, from the end position and the header.
    function wsu_status_e end_status(logic [2:0] pos, logic [7:0] hdr);
      if (pos == 3'd0 || (hdr & HdrFin) == 8'h00) return ST_INVALID;
      if (hdr[3:0] == OpText || hdr[3:0] == OpBinary) begin
        if (pos < PosPayload) return ST_INVALID;
        return (hdr[3:0] == OpText) ? ST_TEXT : ST_BINARY;
      end
      if (hdr[3:0] == OpClose) return ST_CLOSE;
      return ST_INVALID;
    endfunction

    // Notes one accepted input beat and queues the result that it causes.
    function void note_byte(logic [7:0] b, logic last);
      logic [7:0]  hdr;
      wsu_result_t res;
      hdr = (position == 3'd0) ? b : header;
      res = '0;
      if (position == 3'd0) begin
        header  = b;
        key_ptr = '0;
      end else if (position >= PosKey0 && position < PosPayload) begin
        key[8 * int'(position - PosKey0) +: 8] = b;
      end else if (position >= PosPayload) begin
        // Only complete text and binary frames release their payload.
        if ((hdr & HdrFin) != 8'h00 && (hdr[3:0] == OpText || hdr[3:0] == OpBinary)) begin
          res.payload_byte  = b ^ key[8 * int'(key_ptr) +: 8];
          res.payload_valid = 1'b1;
        end
        key_ptr = key_ptr + 2'd1;
      end
      if (last) begin
        res.frame_done   = 1'b1;
        res.frame_status = end_status(position, hdr);
        position = '0;
        key_ptr  = '0;
      end else if (position < PosPayload) begin
        position = position + 3'd1;
      end
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic [7:0] exp, logic [7:0] got);
      if (got !== exp) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, got);
      end
    endfunction

    // Checks one accepted result beat against the oldest expectation.
    function void check_result(logic [7:0] pbyte, logic pvalid, logic done, logic [1:0] status);
      wsu_result_t exp;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, got byte %h valid %b done %b status %0d",
                 $time, pbyte, pvalid, done, status);
        return;
      end
      exp = expected_q.pop_front();
      compare_field("payload_byte", exp.payload_byte, pbyte);
      compare_field("payload_valid", {7'd0, exp.payload_valid}, {7'd0, pvalid});
      compare_field("frame_done", {7'd0, exp.frame_done}, {7'd0, done});
      compare_field("frame_status", {6'd0, exp.frame_status}, {6'd0, status});
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       buffer_end = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] payload_byte_o;
  logic       payload_valid_o;
  logic       frame_done_o;
  logic [1:0] frame_status_o;

  unmask_scoreboard sb;
  int beats_sent = 0;
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int stall_phase = 0;

  websocket_frame_unmask i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte),
    .buffer_end_i   (buffer_end),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .payload_byte_o (payload_byte_o),
    .payload_valid_o(payload_valid_o),
    .frame_done_o   (frame_done_o),
    .frame_status_o (frame_status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

  // Input and output monitors.
  always @(posedge clk_i) begin
    if (rst_n && in_valid && !in_stall_o) sb.note_byte(rx_byte, buffer_end);
    if (rst_n && out_valid_o && !out_stall)
      sb.check_result(payload_byte_o, payload_valid_o, frame_done_o, frame_status_o);
  end

  // Receiver stall: switches between free flow, light, periodic and heavy stalling.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 99) < 30);
      end
      2: begin
        out_stall <= (stall_phase % 3 == 0);
      end
      default: begin
        out_stall <= ($urandom_range(0, 99) < 75);
      end
    endcase
  end

  // Ends a burst, usually with a random gap, once its length runs out.
  task automatic pace();
    int gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid   <= 1'b0;
        rx_byte    <= 8'($urandom);
        buffer_end <= 1'($urandom);
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
    end
  endtask

  // Presents one beat and holds it until it is taken.
  task automatic send_beat(input logic [7:0] b, input logic last);
    @(negedge clk_i);
    in_valid   <= 1'b1;
    rx_byte    <= b;
    buffer_end <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    beats_sent++;
    pace();
  endtask

  task automatic send_buffer(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
  endtask

  // Holds the sender until every expected result has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Builds one buffer: mostly well formed data frames, then close frames,
  // data frames cut short and frames with an arbitrary header.
  task automatic send_random_frame();
    int         kind;
    int         len;
    logic [7:0] hdr;
    logic [7:0] bytes[$];
    kind = $urandom_range(0, 99);
    hdr  = 8'($urandom);
    if (kind < 70) begin
      hdr = {1'b1, hdr[6:4], ($urandom_range(0, 1) == 1) ? OpText : OpBinary};
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(7, 20);
    end else if (kind < 80) begin
      hdr = {1'b1, hdr[6:4], OpClose};
      len = $urandom_range(2, 10);
    end else if (kind < 90) begin
      hdr = {1'b1, hdr[6:4], ($urandom_range(0, 1) == 1) ? OpText : OpBinary};
      len = $urandom_range(1, 6);
    end else begin
      len = $urandom_range(1, 12);
    end
    bytes.push_back(hdr);
    for (int i = 1; i < len; i++) bytes.push_back(8'($urandom));
    send_buffer(bytes);
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;

    // Directed buffers: one byte, text and binary with extreme key and payload,
    // close, data frame ending in the key, FIN clear and an unknown opcode.
    send_buffer('{8'h81});
    send_buffer('{8'h81, 8'h81, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF});
    send_buffer('{8'h88, 8'h80});
    send_buffer('{8'h82, 8'h82, 8'h11, 8'h22, 8'h33, 8'h44});
    send_buffer('{8'h01, 8'h00});
    send_buffer('{8'hFF, 8'hFF});
    send_buffer('{8'h82, 8'hFE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
    drain();

    // Random buffers, with one full pause around the middle.
    while (beats_sent < 550) send_random_frame();
    drain();
    while (beats_sent < 1075) send_random_frame();

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d result beats never arrived", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/wsu_pkg.sv
src/wsu_in_reg.sv
src/wsu_unmask.sv
src/websocket_frame_unmask.sv
test/websocket_frame_unmask_tb.sv
